// ===== sv/ecz_pkg.sv =====
// ecz_pkg: widths, pipeline lengths, arctangent table and helpers for the
// pose-to-euler block. Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ecz_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int GUARD_BITS   = 16;
  localparam int TABLE_FRAC   = 24;
  localparam int TABLE_LEN    = 24;

  localparam int ROT_W  = 18;
  localparam int POS_W  = 32;
  localparam int THR_W  = 16;
  localparam int ROLL_W = 25;
  localparam int PITCH_W = 24;
  localparam int YAW_W  = 25;

  // cordic operand widths
  localparam int CIN_W = ROT_W + 1;
  localparam int XY_W  = CIN_W + GUARD_BITS + 3;
  localparam int Z_W   = FRAC_BITS + 11;

  // square root widths
  localparam int SQ_W   = 2 * ROT_W;
  localparam int ROOT_W = ROT_W;
  localparam int REM_W  = ROOT_W + 3;

  // pipeline lengths
  localparam int SQRT_LAT   = 2 + ROOT_W;
  localparam int CORDIC_LAT = 1 + CORDIC_STEPS;
  localparam int TOTAL_LAT  = SQRT_LAT + CORDIC_LAT + 1;

  localparam int ATAN_SH = TABLE_FRAC - FRAC_BITS;

  localparam logic [31:0] ATAN_Q24 [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115
  };

  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(180) <<< FRAC_BITS;
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(90) <<< FRAC_BITS;

  typedef struct packed {
    logic signed [ROT_W-1:0] r00;
    logic signed [ROT_W-1:0] r10;
    logic signed [ROT_W-1:0] r20;
    logic signed [ROT_W-1:0] r01;
    logic signed [ROT_W-1:0] r11;
    logic signed [ROT_W-1:0] r21;
    logic signed [ROT_W-1:0] r22;
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic [POS_W-1:0]        pz;
  } pose_t;

  typedef struct packed {
    logic [ROOT_W-1:0] r;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
  } tail_t;

  // atan(2^-i) in degrees, rounded half up to FRAC_BITS
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic [32:0] rnd;
    rnd = ({1'b0, ATAN_Q24[i]} + ((33'd1 << ATAN_SH) >> 1)) >> ATAN_SH;
    return Z_W'(rnd);
  endfunction

  function automatic logic signed [Z_W-1:0] clamp(input logic signed [Z_W-1:0] v,
                                                  input logic signed [Z_W-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ecz_sqrt.sv =====
// ecz_sqrt: pipelined r = floor(sqrt(r00^2 + r10^2)), one root bit a stage.
// Depends on ecz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecz_sqrt import ecz_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [ROT_W-1:0] a,
  input  wire logic signed [ROT_W-1:0] b,
  output logic [ROOT_W-1:0]            root
);

  logic signed [SQ_W-1:0] pa_r, pb_r;
  logic [SQ_W-1:0]   n_r    [ROOT_W+1];
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  // one digit pair per stage
  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] t;
      sh = {rem_r[i][REM_W-3:0], n_r[i][SQ_W-1-2*i -: 2]};
      t  = {1'b0, root_r[i], 2'b01};
      if (sh >= t) begin
        rem_nxt[i]  = sh - t;
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = sh;
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // squares, sum, then root stages
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r      <= a * a;
      pb_r      <= b * b;
      n_r[0]    <= pa_r + pb_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int i = 0; i < ROOT_W; i++) begin
        n_r[i+1]    <= n_r[i];
        rem_r[i+1]  <= rem_nxt[i];
        root_r[i+1] <= root_nxt[i];
      end
    end
  end

  assign root = root_r[ROOT_W];

endmodule
`default_nettype wire

// ===== sv/ecz_cordic.sv =====
// ecz_cordic: unrolled cordic vectoring lane giving atan2(y, x) in degrees.
// Depends on ecz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecz_cordic import ecz_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [CIN_W-1:0] x_in,
  input  wire logic signed [CIN_W-1:0] y_in,
  output logic signed [Z_W-1:0]        z_out
);

  logic signed [XY_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS+1];
  logic                   zero_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] xg, yg;

  assign xg = XY_W'(x_in) <<< GUARD_BITS;
  assign yg = XY_W'(y_in) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      // pre-rotation by half a turn for negative x
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -xg;
        y_r[0] <= -yg;
        z_r[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        x_r[0] <= xg;
        y_r[0] <= yg;
        z_r[0] <= '0;
      end
      // micro-rotations
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  assign z_out = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== sv/pose_matrix_to_euler_zyx.sv =====
// Block usage
//   in_*  : one pose request per accepted beat, rotation entries and translation
//   out_* : one result per request, translation and roll, pitch, yaw in degrees
//   cfg_* : write of the degenerate threshold, always ready, reset value 1
// The pipeline holds a squares stage and a sum stage, 18 stages
// of square root (one root bit each), 17 stages of cordic (pre-rotation and
// 16 micro-rotations, four lanes side by side) and one select/clamp stage.
// Unless the output stalls, a new request is taken every cycle (one pose per cycle).
// When the receiver stalls, every stage holds and in_tready falls, so no
// result is lost or repeated. Reset clears all valid bits and sets the
// threshold to 1; payload registers are not reset.
// Depends on ecz_pkg, ecz_sqrt and ecz_cordic.
`timescale 1ns / 1ps
`default_nettype none
module pose_matrix_to_euler_zyx import ecz_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // rot_00, rot_10, rot_20, rot_01, rot_11, rot_21, rot_22, pos_x, pos_y, pos_z
  input  wire logic [223:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x, out_y, out_z, roll_deg, pitch_deg, yaw_deg
  output logic [175:0]      out_tdata,
  // degenerate
  output logic              out_tuser,
  input  wire logic         cfg_tvalid,
  output logic              cfg_tready,
  // degenerate_threshold
  input  wire logic [15:0]  cfg_tdata
);

  logic en;
  logic [THR_W-1:0] thr_r;
  logic vld_r [TOTAL_LAT];
  pose_t pose_in;
  pose_t pose_r [SQRT_LAT];
  tail_t tail_r [CORDIC_LAT];
  logic [ROOT_W-1:0] root;
  logic signed [Z_W-1:0] z_pitch, z_yaw, z_roll, z_alt;
  logic signed [Z_W-1:0] pitch_c, yaw_c, roll_c, alt_c;
  logic degen;
  pose_t pd;

  assign en         = !vld_r[TOTAL_LAT-1] || out_tready;
  assign in_tready  = en;
  assign cfg_tready = 1'b1;
  assign out_tvalid = vld_r[TOTAL_LAT-1];

  // unpack request
  assign pose_in.r00 = in_tdata[17:0];
  assign pose_in.r10 = in_tdata[35:18];
  assign pose_in.r20 = in_tdata[53:36];
  assign pose_in.r01 = in_tdata[71:54];
  assign pose_in.r11 = in_tdata[89:72];
  assign pose_in.r21 = in_tdata[107:90];
  assign pose_in.r22 = in_tdata[125:108];
  assign pose_in.px  = in_tdata[157:126];
  assign pose_in.py  = in_tdata[189:158];
  assign pose_in.pz  = in_tdata[221:190];

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_tvalid) begin
      thr_r <= cfg_tdata;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < TOTAL_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  ecz_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .a    (pose_in.r00),
    .b    (pose_in.r10),
    .root (root)
  );

  // payload beside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      pose_r[0] <= pose_in;
      for (int i = 1; i < SQRT_LAT; i++) pose_r[i] <= pose_r[i-1];
    end
  end

  assign pd = pose_r[SQRT_LAT-1];

  ecz_cordic u_pitch (
    .clk (clk), .en (en),
    .x_in ({1'b0, root}),
    .y_in (-CIN_W'(pd.r20)),
    .z_out (z_pitch)
  );

  ecz_cordic u_yaw (
    .clk (clk), .en (en),
    .x_in (CIN_W'(pd.r00)),
    .y_in (CIN_W'(pd.r10)),
    .z_out (z_yaw)
  );

  ecz_cordic u_roll (
    .clk (clk), .en (en),
    .x_in (CIN_W'(pd.r22)),
    .y_in (CIN_W'(pd.r21)),
    .z_out (z_roll)
  );

  ecz_cordic u_alt (
    .clk (clk), .en (en),
    .x_in (CIN_W'(pd.r11)),
    .y_in (CIN_W'(pd.r01)),
    .z_out (z_alt)
  );

  // payload beside the cordic lanes
  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= '{r: root, px: pd.px, py: pd.py, pz: pd.pz};
      for (int i = 1; i < CORDIC_LAT; i++) tail_r[i] <= tail_r[i-1];
    end
  end

  // gimbal-lock select and clamping
  assign pitch_c = clamp(z_pitch, QUARTER_TURN);
  assign yaw_c   = clamp(z_yaw, HALF_TURN);
  assign roll_c  = clamp(z_roll, HALF_TURN);
  assign alt_c   = clamp(z_alt, HALF_TURN);
  assign degen   = {1'b0, tail_r[CORDIC_LAT-1].r} <= (ROOT_W + 1)'(thr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata[31:0]    <= tail_r[CORDIC_LAT-1].px;
      out_tdata[63:32]   <= tail_r[CORDIC_LAT-1].py;
      out_tdata[95:64]   <= tail_r[CORDIC_LAT-1].pz;
      out_tdata[144:121] <= pitch_c[PITCH_W-1:0];
      out_tdata[175:170] <= '0;
      out_tuser          <= degen;
      if (degen) begin
        out_tdata[120:96]  <= (pitch_c > 0) ? alt_c[ROLL_W-1:0] : -alt_c[ROLL_W-1:0];
        out_tdata[169:145] <= '0;
      end else begin
        out_tdata[120:96]  <= roll_c[ROLL_W-1:0];
        out_tdata[169:145] <= yaw_c[YAW_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/pose_matrix_to_euler_zyx_tb.sv =====
// Testbench for pose_matrix_to_euler_zyx: directed table then random poses,
// each checked against a typed answer or an in-bench predictor of roll,
// pitch and yaw. Depends on ecz_pkg and the block's RTL only.
`timescale 1ns / 1ps
module pose_matrix_to_euler_zyx_tb;
  import ecz_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_WAIT = TOTAL_LAT + 12;

  typedef struct {
    logic signed [17:0] r00, r10, r20, r01, r11, r21, r22;
    logic [31:0] px, py, pz;
  } pose_req_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [24:0] roll;
    logic [23:0] pitch;
    logic [24:0] yaw;
    logic degen;
  } euler_t;

  typedef struct {
    pose_req_t p;
    bit typed;
    euler_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic out_tuser;
  logic cfg_tvalid = 1'b0;
  logic cfg_tready;
  logic [15:0] cfg_tdata = '0;

  euler_t angles_due[$];
  logic [15:0] lock_threshold;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  pose_matrix_to_euler_zyx dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring arctangent in degrees with FRAC_BITS fraction bits
  function automatic longint atan2_deg(longint y, longint x);
    longint z, xs, ys, step;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * (64'sd1 << GUARD_BITS);
    y = y * (64'sd1 << GUARD_BITS);
    if (x < 0) begin
      z = (y >= 0) ? (64'sd180 << FRAC_BITS) : -(64'sd180 << FRAC_BITS);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      step = (longint'(ATAN_Q24[i]) + (64'sd1 << (TABLE_FRAC - FRAC_BITS - 1)))
             >>> (TABLE_FRAC - FRAC_BITS);
      if (y >= 0) begin
        x += ys; y -= xs; z += step;
      end else begin
        x -= ys; y += xs; z -= step;
      end
    end
    return z;
  endfunction

  function automatic longint bound(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic euler_t predict_euler(pose_req_t p);
    euler_t e;
    longint r, pitch, roll, yaw, a;
    r = root_floor(longint'(p.r00) * p.r00 + longint'(p.r10) * p.r10);
    pitch = bound(atan2_deg(-longint'(p.r20), r), 64'sd90 << FRAC_BITS);
    e.degen = (r <= longint'(lock_threshold));
    if (e.degen) begin
      a = bound(atan2_deg(p.r01, p.r11), 64'sd180 << FRAC_BITS);
      yaw = 0;
      roll = (pitch > 0) ? a : -a;
    end else begin
      yaw = bound(atan2_deg(p.r10, p.r00), 64'sd180 << FRAC_BITS);
      roll = bound(atan2_deg(p.r21, p.r22), 64'sd180 << FRAC_BITS);
    end
    e.x = p.px; e.y = p.py; e.z = p.pz;
    e.roll = roll[24:0];
    e.pitch = pitch[23:0];
    e.yaw = yaw[24:0];
    return e;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %h expected %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    euler_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (angles_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 0);
      end else begin
        w = angles_due.pop_front();
        if (out_tdata[31:0] !== w.x) report_mismatch("out_x", out_tdata[31:0], w.x);
        if (out_tdata[63:32] !== w.y) report_mismatch("out_y", out_tdata[63:32], w.y);
        if (out_tdata[95:64] !== w.z) report_mismatch("out_z", out_tdata[95:64], w.z);
        if (out_tdata[120:96] !== w.roll) report_mismatch("roll", out_tdata[120:96], w.roll);
        if (out_tdata[144:121] !== w.pitch)
          report_mismatch("pitch", out_tdata[144:121], w.pitch);
        if (out_tdata[169:145] !== w.yaw) report_mismatch("yaw", out_tdata[169:145], w.yaw);
        if (out_tuser !== w.degen) report_mismatch("degenerate", out_tuser, w.degen);
      end
    end
  end

  task automatic send_pose(pose_req_t p, bit typed, euler_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, p.pz, p.py, p.px, p.r22, p.r21, p.r11, p.r01, p.r20, p.r10, p.r00};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angles_due.push_back(typed ? want : predict_euler(p));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= v;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    lock_threshold = v;
  endtask

  function automatic pose_req_t random_pose(int thr);
    pose_req_t p;
    int span;
    p.r00 = 18'($urandom_range(0, 262143));
    p.r10 = 18'($urandom_range(0, 262143));
    p.r20 = 18'($urandom_range(0, 262143));
    p.r01 = 18'($urandom_range(0, 262143));
    p.r11 = 18'($urandom_range(0, 262143));
    p.r21 = 18'($urandom_range(0, 262143));
    p.r22 = 18'($urandom_range(0, 262143));
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    // near gimbal lock: r around the threshold
    if ($urandom_range(0, 3) == 0) begin
      span = (thr > 60000) ? 60000 : thr + 3;
      p.r00 = 18'(int'($urandom_range(0, 2 * span)) - span);
      p.r10 = 18'(int'($urandom_range(0, 2 * span)) - span);
    end
    return p;
  endfunction

  function automatic pose_req_t mk(int a, int b, int c, int d, int e, int f, int g,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pose_req_t p;
    p.r00 = 18'(a); p.r10 = 18'(b); p.r20 = 18'(c); p.r01 = 18'(d);
    p.r11 = 18'(e); p.r21 = 18'(f); p.r22 = 18'(g);
    p.px = x; p.py = y; p.pz = z;
    return p;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    euler_t none;
    logic [15:0] thresholds[6];
    int idles[6], stalls[6];

    none = '{default: '0};
    lock_threshold = 16'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, zero matrix has a readable answer
    row.typed = 1'b1; row.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.want = '{x: 0, y: 0, z: 0, roll: 0, pitch: 0, yaw: 0, degen: 1'b1};
    rows.push_back(row);
    row.typed = 1'b1;
    row.p = mk(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    row.want = '{x: 32'h7fffffff, y: 32'h80000000, z: 32'hffffffff,
                 roll: 0, pitch: 0, yaw: 0, degen: 1'b1};
    rows.push_back(row);
    row.typed = 1'b0; row.want = none;
    row.p = mk(65536, 0, 0, 0, 65536, 0, 65536, 1, 2, 3); rows.push_back(row);
    row.p = mk(131071, 131071, 131071, 131071, 131071, 131071, 131071, 0, 0, 0);
    rows.push_back(row);
    row.p = mk(-131072, -131072, -131072, -131072, -131072, -131072, -131072,
               32'h80000000, 32'h7fffffff, 0);
    rows.push_back(row);
    // negative x turned by half a turn, both signs of y
    row.p = mk(-65536, 100, 0, 0, -65536, 5, -65536, 0, 0, 0); rows.push_back(row);
    row.p = mk(-65536, -100, 0, 0, -65536, -5, -65536, 0, 0, 0); rows.push_back(row);
    row.p = mk(-65536, 0, 0, 0, 65536, 0, -65536, 0, 0, 0); rows.push_back(row);
    // gimbal lock with pitch up and down
    row.p = mk(0, 0, -65536, 30000, 50000, 0, 0, 7, 8, 9); rows.push_back(row);
    row.p = mk(0, 0, 65536, 30000, 50000, 0, 0, 7, 8, 9); rows.push_back(row);
    row.p = mk(0, 0, -131072, -131072, 131071, 0, 0, 0, 0, 0); rows.push_back(row);
    // r right at and just past the threshold
    row.p = mk(1, 0, -65536, 40000, -40000, 100, 100, 0, 0, 0); rows.push_back(row);
    row.p = mk(-1, 0, 65536, 40000, -40000, 100, 100, 0, 0, 0); rows.push_back(row);
    row.p = mk(2, 0, -65536, 40000, -40000, 100, 100, 0, 0, 0); rows.push_back(row);
    row.p = mk(1, 1, -65536, 40000, -40000, 100, 100, 0, 0, 0); rows.push_back(row);
    // pitch pushed to the quarter-turn limit
    row.p = mk(0, 1, -131072, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.p = mk(0, 2, 131071, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.p = mk(0, 0, 0, 0, -1, 0, 0, 0, 0, 0); rows.push_back(row);
    foreach (rows[i]) send_pose(rows[i].p, rows[i].typed, rows[i].want);

    thresholds = '{16'd0, 16'd65535, 16'd300, 16'd1, 16'd40000, 16'd65534};
    idles  = '{0, 55, 0, 19, 0, 55};
    stalls = '{0, 0, 55, 19, 0, 55};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      send_idle_pct = idles[ph];
      recv_stall_pct = stalls[ph];
      write_threshold(thresholds[ph]);
      for (int n = 0; n < 200; n++) begin
        // hold off until the pipe is empty once
        if (ph == 2 && n == 100) begin
          in_tvalid <= 1'b0;
          while (angles_due.size() != 0) @(posedge clk);
        end
        send_pose(random_pose(thresholds[ph]), 1'b0, none);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
